// ----- rtl/pva_pkg.sv -----
// Shared types and codes for the polyphonic voice allocator.
package pva_pkg;

   localparam logic [1:0] KIND_NOTE_ON  = 2'd0;
   localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
   localparam logic [1:0] KIND_ENERGY   = 2'd2;
   localparam logic [1:0] KIND_FINISH   = 2'd3;

   localparam logic [1:0] ACT_NONE     = 2'd0;
   localparam logic [1:0] ACT_STARTED  = 2'd1;
   localparam logic [1:0] ACT_RELEASED = 2'd2;
   localparam logic [1:0] ACT_UPDATED  = 2'd3;

   localparam logic [15:0] CEILING_RESET = 16'd32000;

   typedef enum logic [1:0] {
      OP_START   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_ENERGY  = 2'd2,
      OP_FINISH  = 2'd3
   } cell_op_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [6:0]  note;
      logic [3:0]  channel;
      logic [2:0]  voice_index;
      logic [15:0] energy_level;
   } req_word_type;

   typedef struct packed {
      logic [1:0] action;
      logic [2:0] voice;
      logic       stolen;
   } rsp_word_type;

   typedef struct packed {
      logic        active;
      logic        releasing;
      logic [6:0]  note;
      logic [3:0]  channel;
      logic [15:0] energy;
   } voice_rec_type;

   typedef struct packed {
      logic        valid;
      cell_op_type op;
      logic [6:0]  note;
      logic [3:0]  channel;
      logic [15:0] energy;
   } cell_cmd_type;

   typedef struct packed {
      logic free_found;
      logic free_sounding;
      logic rel_found;
      logic off_found;
   } scan_flags_type;

endpackage

// ----- rtl/pva_cell.sv -----
// One voice cell of the rotating ring: holds a voice record and its tag.
module pva_cell #(
   parameter int IW = 3,
   parameter int ID = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   shift,
   input  pva_pkg::voice_rec_type rec_next,
   input  logic [IW-1:0]          tag_next,
   input  pva_pkg::cell_cmd_type  cmd,
   input  logic [IW-1:0]          cmd_tag,
   output pva_pkg::voice_rec_type rec_out,
   output logic [IW-1:0]          tag_out
);

   pva_pkg::voice_rec_type rec_ff, rec_in;
   logic [IW-1:0]          tag_ff, tag_in;

   always_comb begin
      rec_in = rec_ff;
      tag_in = tag_ff;
      if (shift) begin
         rec_in = rec_next;
         tag_in = tag_next;
      end else if (cmd.valid && cmd_tag == tag_ff) begin
         case (cmd.op)
            pva_pkg::OP_START: begin
               rec_in.active    = 1'b1;
               rec_in.releasing = 1'b0;
               rec_in.note      = cmd.note;
               rec_in.channel   = cmd.channel;
               rec_in.energy    = '0;
            end
            pva_pkg::OP_RELEASE: begin
               rec_in.releasing = 1'b1;
            end
            pva_pkg::OP_ENERGY: begin
               rec_in.energy = cmd.energy;
            end
            pva_pkg::OP_FINISH: begin
               // channel is left as it was
               rec_in.active    = 1'b0;
               rec_in.releasing = 1'b0;
               rec_in.note      = '0;
               rec_in.energy    = '0;
            end
            default: begin
               rec_in = rec_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff <= '0;
         tag_ff <= IW'(ID);
      end else begin
         rec_ff <= rec_in;
         tag_ff <= tag_in;
      end
   end

   assign rec_out = rec_ff;
   assign tag_out = tag_ff;

endmodule

// ----- rtl/pva_scan.sv -----
// Head-of-ring evaluator: gathers free, steal, highest-note and note-off picks.
module pva_scan #(
   parameter int IW = 3
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    clear,
   input  logic                    step,
   input  pva_pkg::voice_rec_type  head,
   input  logic [IW-1:0]           head_tag,
   input  logic [6:0]              note,
   input  logic [3:0]              channel,
   input  logic [15:0]             ceiling,
   output pva_pkg::scan_flags_type flags,
   output logic [IW-1:0]           free_idx,
   output logic [IW-1:0]           rel_idx,
   output logic [IW-1:0]           max_idx,
   output logic [IW-1:0]           off_idx
);

   pva_pkg::scan_flags_type flags_ff, flags_in;
   logic [IW-1:0] free_idx_ff, free_idx_in;
   logic [IW-1:0] rel_idx_ff, rel_idx_in;
   logic [IW-1:0] max_idx_ff, max_idx_in;
   logic [IW-1:0] off_idx_ff, off_idx_in;
   logic [15:0]   emin_ff, emin_in;
   logic [6:0]    nmax_ff, nmax_in;

   always_comb begin
      flags_in    = flags_ff;
      free_idx_in = free_idx_ff;
      rel_idx_in  = rel_idx_ff;
      max_idx_in  = max_idx_ff;
      off_idx_in  = off_idx_ff;
      emin_in     = emin_ff;
      nmax_in     = nmax_ff;
      if (clear) begin
         flags_in    = '0;
         free_idx_in = '0;
         rel_idx_in  = '0;
         max_idx_in  = '0;
         off_idx_in  = '0;
         emin_in     = ceiling;
         nmax_in     = '0;
      end else if (step) begin
         // first idle voice or one already on this note
         if (!flags_ff.free_found && (!head.active || head.note == note)) begin
            flags_in.free_found    = 1'b1;
            flags_in.free_sounding = head.active;
            free_idx_in            = head_tag;
         end
         // strict compare keeps the lowest index on ties
         if (head.releasing && head.energy < emin_ff) begin
            flags_in.rel_found = 1'b1;
            emin_in            = head.energy;
            rel_idx_in         = head_tag;
         end
         if (head.note > nmax_ff) begin
            nmax_in    = head.note;
            max_idx_in = head_tag;
         end
         if (!flags_ff.off_found && head.note == note && head.channel == channel &&
             head.active && !head.releasing) begin
            flags_in.off_found = 1'b1;
            off_idx_in         = head_tag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      free_idx_ff <= free_idx_in;
      rel_idx_ff  <= rel_idx_in;
      max_idx_ff  <= max_idx_in;
      off_idx_ff  <= off_idx_in;
      emin_ff     <= emin_in;
      nmax_ff     <= nmax_in;
   end

   assign flags    = flags_ff;
   assign free_idx = free_idx_ff;
   assign rel_idx  = rel_idx_ff;
   assign max_idx  = max_idx_ff;
   assign off_idx  = off_idx_ff;

endmodule

// ----- rtl/polyphonic_voice_allocator.sv -----
// Voice allocator with voice stealing built as a rotating ring of voice cells.
// Idle takes start, scan turns the ring, decide registers the result strobe.
// Busy until done; the ring turns once per event, one cell a cycle.
// The result is shown for one cycle only; the receiver cannot stall it.
// Reset (synchronous): all voices idle with zero note, channel and energy; ceiling 32000.
module polyphonic_voice_allocator #(
   parameter int VOICES = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  pva_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   output pva_pkg::rsp_word_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [15:0]           csr_data
);

   localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_DECIDE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   pva_pkg::req_word_type req_ff;
   logic [15:0] ceiling_ff;
   logic rsp_valid_ff;
   pva_pkg::rsp_word_type rsp_data_ff, rsp_data_in;

   logic accept;
   logic shift;

   pva_pkg::voice_rec_type rec [VOICES];
   logic [IW-1:0]          tag [VOICES];

   pva_pkg::cell_cmd_type cmd;
   logic [IW-1:0]         cmd_tag;

   pva_pkg::scan_flags_type flags;
   logic [IW-1:0] free_idx, rel_idx, max_idx, off_idx;
   logic vi_ok;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign shift     = (state_ff == ST_SCAN);
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ceiling_ff <= pva_pkg::CEILING_RESET;
      end else if (csr_valid && csr_ready) begin
         ceiling_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   // ring of cells: each hands its record to the one below, cell 0 wraps to the top
   for (genvar i = 0; i < VOICES; i++) begin : g_cell
      localparam int NX = (i + 1) % VOICES;
      pva_cell #(
         .IW(IW),
         .ID(i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .shift   (shift),
         .rec_next(rec[NX]),
         .tag_next(tag[NX]),
         .cmd     (cmd),
         .cmd_tag (cmd_tag),
         .rec_out (rec[i]),
         .tag_out (tag[i])
      );
   end

   pva_scan #(
      .IW(IW)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .clear   (accept),
      .step    (shift),
      .head    (rec[0]),
      .head_tag(tag[0]),
      .note    (req_ff.note),
      .channel (req_ff.channel),
      .ceiling (ceiling_ff),
      .flags   (flags),
      .free_idx(free_idx),
      .rel_idx (rel_idx),
      .max_idx (max_idx),
      .off_idx (off_idx)
   );

   assign vi_ok = (32'(req_ff.voice_index) < VOICES);

   // decide the target and broadcast the update once the ring is back home
   always_comb begin
      cmd         = '0;
      cmd.op      = pva_pkg::OP_START;
      cmd.note    = req_ff.note;
      cmd.channel = req_ff.channel;
      cmd.energy  = req_ff.energy_level;
      cmd_tag     = '0;
      rsp_data_in = '0;
      case (req_ff.kind)
         pva_pkg::KIND_NOTE_ON: begin
            cmd.op = pva_pkg::OP_START;
            if (flags.free_found) begin
               cmd_tag            = free_idx;
               rsp_data_in.stolen = flags.free_sounding;
            end else begin
               cmd_tag            = flags.rel_found ? rel_idx : max_idx;
               rsp_data_in.stolen = 1'b1;
            end
            cmd.valid          = 1'b1;
            rsp_data_in.action = pva_pkg::ACT_STARTED;
            rsp_data_in.voice  = 3'(cmd_tag);
         end
         pva_pkg::KIND_NOTE_OFF: begin
            cmd.op  = pva_pkg::OP_RELEASE;
            cmd_tag = off_idx;
            if (flags.off_found) begin
               cmd.valid          = 1'b1;
               rsp_data_in.action = pva_pkg::ACT_RELEASED;
               rsp_data_in.voice  = 3'(off_idx);
            end
         end
         default: begin
            cmd.op  = (req_ff.kind == pva_pkg::KIND_ENERGY) ?
                      pva_pkg::OP_ENERGY : pva_pkg::OP_FINISH;
            cmd_tag = IW'(req_ff.voice_index);
            if (vi_ok) begin
               cmd.valid          = 1'b1;
               rsp_data_in.action = pva_pkg::ACT_UPDATED;
               rsp_data_in.voice  = req_ff.voice_index;
            end
         end
      endcase
      if (state_ff != ST_DECIDE) begin
         cmd.valid = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == IW'(VOICES - 1)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= (state_ff == ST_DECIDE);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DECIDE) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result word while an event is in progress");

   a_rsp_after_decide: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_DECIDE))
      else $error("result word without a decide cycle");

   a_ring_home: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) |-> (tag[0] == '0))
      else $error("ring not back in place at decide");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy && !rsp_valid)
      else $error("accepted word did not start a scan");

endmodule

// ----- tb/polyphonic_voice_allocator_checker.sv -----
// Checker for the voice allocator: predicts each event's result and compares it.
`timescale 1ns / 1ps

module polyphonic_voice_allocator_checker #(
   parameter int VOICES = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  pva_pkg::req_word_type req_data,
   input  logic                  rsp_valid,
   input  pva_pkg::rsp_word_type rsp_data,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [15:0]           csr_data,
   output int                    mismatch_count,
   output int                    pending_count,
   output int                    results_seen,
   output int                    steals_seen
);

   pva_pkg::voice_rec_type voice_tab [VOICES];
   logic [15:0]            steal_ceiling;
   pva_pkg::rsp_word_type  expected_words [$];
   int                     errors;
   int                     checked;
   int                     steals;

   // Apply one event to the voice table and return the word it should produce.
   function automatic pva_pkg::rsp_word_type allocate_voice(input pva_pkg::req_word_type w);
      pva_pkg::rsp_word_type r;
      int                    pick;
      logic [15:0]           emin;
      logic [6:0]            nmax;
      r    = '0;
      pick = -1;
      case (w.kind)
         pva_pkg::KIND_NOTE_ON: begin
            for (int v = 0; v < VOICES; v++) begin
               if (pick < 0 && (!voice_tab[v].active || voice_tab[v].note == w.note)) begin
                  pick     = v;
                  r.stolen = voice_tab[v].active;
               end
            end
            if (pick < 0) begin
               r.stolen = 1'b1;
               emin     = steal_ceiling;
               for (int v = 0; v < VOICES; v++) begin
                  if (voice_tab[v].releasing && voice_tab[v].energy < emin) begin
                     emin = voice_tab[v].energy;
                     pick = v;
                  end
               end
            end
            // no quiet releasing voice: take the highest note, lowest index on ties
            if (pick < 0) begin
               pick = 0;
               nmax = '0;
               for (int v = 0; v < VOICES; v++) begin
                  if (voice_tab[v].note > nmax) begin
                     nmax = voice_tab[v].note;
                     pick = v;
                  end
               end
            end
            voice_tab[pick].active    = 1'b1;
            voice_tab[pick].releasing = 1'b0;
            voice_tab[pick].note      = w.note;
            voice_tab[pick].channel   = w.channel;
            voice_tab[pick].energy    = '0;
            r.action = pva_pkg::ACT_STARTED;
            r.voice  = 3'(pick);
         end
         pva_pkg::KIND_NOTE_OFF: begin
            for (int v = 0; v < VOICES; v++) begin
               if (pick < 0 && voice_tab[v].note == w.note && voice_tab[v].channel == w.channel
                   && voice_tab[v].active && !voice_tab[v].releasing) begin
                  pick = v;
               end
            end
            if (pick >= 0) begin
               voice_tab[pick].releasing = 1'b1;
               r.action = pva_pkg::ACT_RELEASED;
               r.voice  = 3'(pick);
            end
         end
         default: begin
            if (int'(w.voice_index) < VOICES) begin
               if (w.kind == pva_pkg::KIND_ENERGY) begin
                  voice_tab[w.voice_index].energy = w.energy_level;
               end else begin
                  voice_tab[w.voice_index].active    = 1'b0;
                  voice_tab[w.voice_index].releasing = 1'b0;
                  voice_tab[w.voice_index].note      = '0;
                  voice_tab[w.voice_index].energy    = '0;
               end
               r.action = pva_pkg::ACT_UPDATED;
               r.voice  = w.voice_index;
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      pva_pkg::rsp_word_type exp_word;
      if (reset) begin
         for (int v = 0; v < VOICES; v++) voice_tab[v] = '0;
         steal_ceiling = pva_pkg::CEILING_RESET;
         expected_words.delete();
         errors  = 0;
         checked = 0;
         steals  = 0;
      end else begin
         if (csr_valid && csr_ready) steal_ceiling = csr_data;
         // check before queueing: a word leaving now belongs to an earlier event
         if (rsp_valid) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected result word, actual action %0d voice %0d stolen %0d",
                        $time, rsp_data.action, rsp_data.voice, rsp_data.stolen);
               errors++;
            end else begin
               exp_word = expected_words.pop_front();
               checked++;
               if (rsp_data.stolen) steals++;
               if (rsp_data.action !== exp_word.action) begin
                  $display("%0t: action mismatch, expected %0d actual %0d",
                           $time, exp_word.action, rsp_data.action);
                  errors++;
               end
               if (rsp_data.voice !== exp_word.voice) begin
                  $display("%0t: voice mismatch, expected %0d actual %0d",
                           $time, exp_word.voice, rsp_data.voice);
                  errors++;
               end
               if (rsp_data.stolen !== exp_word.stolen) begin
                  $display("%0t: stolen mismatch, expected %0d actual %0d",
                           $time, exp_word.stolen, rsp_data.stolen);
                  errors++;
               end
            end
         end
         if (start && !busy) expected_words.push_back(allocate_voice(req_data));
      end
      mismatch_count <= errors;
      pending_count  <= expected_words.size();
      results_seen   <= checked;
      steals_seen    <= steals;
   end

endmodule

// ----- tb/polyphonic_voice_allocator_test.sv -----
// Testbench top for the voice allocator: clock, reset, event and ceiling stimulus, verdict.
`timescale 1ns / 1ps

module polyphonic_voice_allocator_test;

   localparam int VOICES       = 8;
   localparam int PHASES       = 6;
   localparam int PHASE_EVENTS = 180;
   localparam int CYCLE_LIMIT  = 200000;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic                  busy;
   pva_pkg::req_word_type req_data  = '0;
   logic                  rsp_valid;
   pva_pkg::rsp_word_type rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [15:0]           csr_data  = '0;

   int mismatch_count;
   int pending_count;
   int results_seen;
   int steals_seen;

   int                    cycle_count  = 0;
   int                    events_sent  = 0;
   int                    directed_sent;
   logic                  idle_on      = 1'b1;
   logic [15:0]           ceiling_now  = pva_pkg::CEILING_RESET;
   logic [15:0]           ceiling_plan [PHASES];
   pva_pkg::req_word_type held_notes [$];

   polyphonic_voice_allocator #(.VOICES(VOICES)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   polyphonic_voice_allocator_checker #(.VOICES(VOICES)) i_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .results_seen   (results_seen),
      .steals_seen    (steals_seen)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("polyphonic_voice_allocator verification failed");
         $finish;
      end
   end

   function automatic pva_pkg::req_word_type make_event(input logic [1:0] kind, input int note,
                                                        input int channel, input int voice_index,
                                                        input int energy);
      pva_pkg::req_word_type w;
      w.kind         = kind;
      w.note         = 7'(note);
      w.channel      = 4'(channel);
      w.voice_index  = 3'(voice_index);
      w.energy_level = 16'(energy);
      return w;
   endfunction

   // Mostly playable traffic: note-offs aim at held notes, energies often sit near the ceiling.
   function automatic pva_pkg::req_word_type next_event();
      pva_pkg::req_word_type w;
      int                    sel;
      int                    idx;
      w   = pva_pkg::req_word_type'($urandom);
      sel = $urandom_range(99);
      if (sel < 10) return w;
      if (sel < 45) begin
         w.kind = pva_pkg::KIND_NOTE_ON;
         if ($urandom_range(3) == 0) w.note = 7'(60 + $urandom_range(3));
         held_notes.push_back(w);
         if (held_notes.size() > 24) void'(held_notes.pop_front());
      end else if (sel < 70) begin
         w.kind = pva_pkg::KIND_NOTE_OFF;
         if (held_notes.size() > 0 && $urandom_range(4) != 0) begin
            idx       = $urandom_range(held_notes.size() - 1);
            w.note    = held_notes[idx].note;
            w.channel = held_notes[idx].channel;
            held_notes.delete(idx);
         end
      end else if (sel < 90) begin
         w.kind = pva_pkg::KIND_ENERGY;
         case ($urandom_range(5))
            0: w.energy_level = '0;
            1: w.energy_level = '1;
            2: w.energy_level = ceiling_now - 16'd1;
            3: w.energy_level = ceiling_now;
            4: w.energy_level = ceiling_now + 16'd1;
            default: ;
         endcase
      end else begin
         w.kind = pva_pkg::KIND_FINISH;
      end
      return w;
   endfunction

   // Hold start high until the word is taken; drop it only when a gap is chosen.
   task automatic send_event(input pva_pkg::req_word_type w);
      int gap;
      if (idle_on && $urandom_range(99) < 27) begin
         gap = $urandom_range(1, 12);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      events_sent++;
   endtask

   task automatic drain_results();
      start <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (VOICES + 4) @(posedge clock);
   endtask

   task automatic write_ceiling(input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid   <= 1'b0;
      ceiling_now  = value;
   endtask

   initial begin
      ceiling_plan = '{pva_pkg::CEILING_RESET, 16'd0, 16'hFFFF, 16'd1, 16'd0,
                       pva_pkg::CEILING_RESET};
      ceiling_plan[4] = 16'($urandom_range(65535));
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, retrigger, filling, both steal paths, ties, the ceiling edge
      send_event(make_event(pva_pkg::KIND_NOTE_OFF, 0, 0, 0, 0));
      send_event(make_event(pva_pkg::KIND_ENERGY, 0, 0, 0, 16'hFFFF));
      send_event(make_event(pva_pkg::KIND_FINISH, 0, 0, 7, 0));
      send_event(make_event(pva_pkg::KIND_NOTE_ON, 0, 0, 0, 0));
      send_event(make_event(pva_pkg::KIND_NOTE_ON, 0, 3, 0, 0));
      send_event(make_event(pva_pkg::KIND_NOTE_ON, 127, 15, 0, 0));
      for (int v = 2; v < VOICES; v++) begin
         send_event(make_event(pva_pkg::KIND_NOTE_ON, v * 10, v - 1, 0, 0));
      end
      send_event(make_event(pva_pkg::KIND_NOTE_ON, 90, 0, 0, 0));
      send_event(make_event(pva_pkg::KIND_NOTE_OFF, 20, 1, 0, 0));
      send_event(make_event(pva_pkg::KIND_NOTE_OFF, 20, 1, 0, 0));
      send_event(make_event(pva_pkg::KIND_NOTE_OFF, 30, 9, 0, 0));
      send_event(make_event(pva_pkg::KIND_NOTE_OFF, 30, 2, 0, 0));
      send_event(make_event(pva_pkg::KIND_ENERGY, 0, 0, 2, 100));
      send_event(make_event(pva_pkg::KIND_ENERGY, 0, 0, 3, 100));
      send_event(make_event(pva_pkg::KIND_NOTE_ON, 100, 7, 0, 0));
      send_event(make_event(pva_pkg::KIND_ENERGY, 0, 0, 3, 32000));
      send_event(make_event(pva_pkg::KIND_NOTE_ON, 110, 8, 0, 0));
      send_event(make_event(pva_pkg::KIND_FINISH, 0, 0, 0, 0));
      send_event(make_event(pva_pkg::KIND_NOTE_ON, 5, 0, 0, 0));
      send_event(make_event(pva_pkg::KIND_ENERGY, 0, 0, 3, 31999));
      send_event(make_event(pva_pkg::KIND_NOTE_ON, 6, 12, 0, 0));
      directed_sent = events_sent;

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            drain_results();
            write_ceiling(ceiling_plan[p]);
         end
         // one phase runs back to back with no gaps
         idle_on = (p != 2);
         repeat (PHASE_EVENTS) send_event(next_event());
      end
      drain_results();

      $display("%0d events driven, %0d of them directed; %0d results checked, %0d steals",
               events_sent, directed_sent, results_seen, steals_seen);
      $display("steal ceilings run: 32000, 0, 65535, 1, %0d and 32000 again", ceiling_plan[4]);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("polyphonic_voice_allocator verification clean");
      end else begin
         $display("polyphonic_voice_allocator verification failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/pva_pkg.sv
rtl/pva_cell.sv
rtl/pva_scan.sv
rtl/polyphonic_voice_allocator.sv
tb/polyphonic_voice_allocator_checker.sv
tb/polyphonic_voice_allocator_test.sv
